/* hdl/cvc_pkg.sv */
// Shared constants and register map of the Casson viscosity clamp.
// No dependencies; every other file of the block imports this package.
package cvc_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REG_YIELD_STRESS      = 2'd0,
    REG_PLASTIC_VISCOSITY = 2'd1,
    REG_VISCOSITY_FLOOR   = 2'd2,
    REG_VISCOSITY_CEILING = 2'd3
  } reg_idx_t;

endpackage

/* hdl/cvc_div.sv */
// Pipelined restoring divider: floor(num * 2^F / max(den, 1)), one quotient bit per stage.
// Saturates to full scale with a flag. Depends on cvc_pkg.
module cvc_div
  import cvc_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         out_valid,
  output logic [W-1:0] quot,
  output logic         sat
);
  localparam int F = W / 2;
  localparam int L = W - F;

  logic [W-1:0] rem  [0:W];
  logic [W-1:0] q    [0:W];
  logic [W-1:0] dv   [0:W];
  logic [L-1:0] lo   [0:W];
  logic         st   [0:W];
  logic         vld  [0:W];

  logic [W-1:0] den_eff;
  assign den_eff = (den == '0) ? W'(1) : den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num >> L);
      q[0]   <= '0;
      dv[0]  <= den_eff;
      lo[0]  <= num[L-1:0];
      st[0]  <= W'(num >> L) >= den_eff;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic         nb;
    logic [W:0]   t;
    logic         ge;
    if (i < L) begin : g_bit
      assign nb = lo[i][L-1-i];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign t  = {rem[i], nb};
    assign ge = t >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? W'(t - {1'b0, dv[i]}) : W'(t);
        q[i+1]   <= {q[i][W-2:0], ge};
        dv[i+1]  <= dv[i];
        lo[i+1]  <= lo[i];
        st[i+1]  <= st[i];
      end
    end
  end

  assign out_valid = vld[W];
  assign sat       = st[W];
  assign quot      = st[W] ? '1 : q[W];

endmodule

/* hdl/cvc_sqrt.sv */
// Pipelined digit-by-digit square root: floor(sqrt(x * 2^F)), one root bit per stage.
// Carries a valid bit and a one-bit tag along. Depends on cvc_pkg.
module cvc_sqrt
  import cvc_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_tag,
  input  logic [W-1:0]                 x,
  output logic                         out_valid,
  output logic                         out_tag,
  output logic [(W+W/2+1)/2-1:0]       root
);
  localparam int F  = W / 2;
  localparam int RW = (W + F + 1) / 2;

  logic [2*RW-1:0] xp  [0:RW];
  logic [RW-1:0]   rt  [0:RW];
  logic [RW+1:0]   rem [0:RW];
  logic            tg  [0:RW];
  logic            vld [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp[0]  <= (2*RW)'({x, {F{1'b0}}});
      rt[0]  <= '0;
      rem[0] <= '0;
      tg[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int P = RW - 1 - k;
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic          ge;
    assign t     = {rem[k][RW:0], xp[k][2*P+1:2*P]};
    assign trial = (RW+3)'({rt[k], 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
        rt[k+1]  <= {rt[k][RW-2:0], ge};
        xp[k+1]  <= xp[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_tag   = tg[RW];
  assign root      = rt[RW];

endmodule

/* hdl/cvc_square_clamp.sv */
// Sum of the two roots, fixed-point square with saturation, and the floor/ceiling clamp.
// Four register stages, the last one being the output register. Depends on cvc_pkg.
module cvc_square_clamp
  import cvc_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic                   in_sat,
  input  logic [(W+W/2+1)/2-1:0] root_a,
  input  logic [(W+W/2+1)/2-1:0] root_b,
  input  logic [W-1:0]           floor_val,
  input  logic [W-1:0]           ceil_val,
  output logic                   out_valid,
  output logic [W-1:0]           nu,
  output logic                   out_sat
);
  localparam int F  = W / 2;
  localparam int RW = (W + F + 1) / 2;
  localparam int PW = 2 * RW + 2;

  logic [3:0]     vld;
  logic [RW:0]    s;
  logic [PW-1:0]  prod;
  logic [W-1:0]   capped;
  logic           sat_a, sat_b, sat_c;
  logic [PW-1:0]  shifted;
  logic           big;
  logic [W-1:0]   sq;

  assign shifted = prod >> F;
  assign big     = (shifted >> W) != '0;
  assign sq      = big ? '1 : W'(shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s      <= (RW+1)'(root_a) + (RW+1)'(root_b);
      sat_a  <= in_sat;
      prod   <= PW'(s) * PW'(s);
      sat_b  <= sat_a;
      capped <= (sq > ceil_val) ? ceil_val : sq;
      sat_c  <= sat_b | big;
      nu     <= (capped < floor_val) ? floor_val : capped;
      out_sat <= sat_c;
    end
  end

  assign out_valid = vld[3];

endmodule

/* hdl/casson_viscosity_clamp.sv */
// Casson viscosity clamp, top level: register file, input stage and the pipeline chain.
// Depends on cvc_pkg, cvc_div, cvc_sqrt and cvc_square_clamp.
//
// Usage: strain rates stream in on the s_axis channel, one unsigned fixed-point item per
// beat, and each item gives exactly one result on the m_axis channel: the clamped
// viscosity in tdata and the overflow flag in tuser. The four coefficients are written
// through the APB port; the user must write them only while no item is in flight, as
// the block itself does not enforce it. Throughput is one item per cycle while the
// receiver does not stall. The result passes through the divider (one quotient bit per
// stage), the square root (one root bit per stage) and the square-and-clamp stages.
// Reset empties the pipeline and loads the register defaults (ceiling at full scale,
// the others zero). When the receiver stalls, the whole pipeline holds and s_axis_tready
// falls in the same cycle, so no item is lost or repeated; bubbles are not squeezed out.
module casson_viscosity_clamp
  import cvc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [(DATA_WIDTH > 32 ? 5 : 4)-1:0] paddr,
  input  logic [(DATA_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
  output logic [(DATA_WIDTH > 32 ? 64 : 32)-1:0] prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // strain_rate
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // viscosity
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // overflow
  output logic                                m_axis_tuser
);
  localparam int W  = DATA_WIDTH;
  localparam int AW = (W > 32) ? 5 : 4;
  localparam int BW = (W > 32) ? 64 : 32;
  localparam int TW = ((W + 7) / 8) * 8;
  localparam int RW = (W + W / 2 + 1) / 2;

  logic [W-1:0] yield_stress, plastic_viscosity, viscosity_floor, viscosity_ceiling;
  reg_idx_t     widx;
  logic         en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[AW-1:AW-2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      yield_stress      <= '0;
      plastic_viscosity <= '0;
      viscosity_floor   <= '0;
      viscosity_ceiling <= '1;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_YIELD_STRESS:      yield_stress      <= pwdata[W-1:0];
        REG_PLASTIC_VISCOSITY: plastic_viscosity <= pwdata[W-1:0];
        REG_VISCOSITY_FLOOR:   viscosity_floor   <= pwdata[W-1:0];
        REG_VISCOSITY_CEILING: viscosity_ceiling <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_YIELD_STRESS:      prdata = BW'(yield_stress);
      REG_PLASTIC_VISCOSITY: prdata = BW'(plastic_viscosity);
      REG_VISCOSITY_FLOOR:   prdata = BW'(viscosity_floor);
      REG_VISCOSITY_CEILING: prdata = BW'(viscosity_ceiling);
      default:               prdata = '0;
    endcase
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic         q_valid, q_sat;
  logic [W-1:0] q;
  logic         ra_valid, ra_sat, rb_valid, rb_tag;
  logic [RW-1:0] ra, rb;
  logic [W-1:0] nu;

  cvc_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid),
    .num(yield_stress), .den(s_axis_tdata[W-1:0]),
    .out_valid(q_valid), .quot(q), .sat(q_sat)
  );

  cvc_sqrt #(.W(W)) u_sqrt_q (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .in_tag(q_sat), .x(q),
    .out_valid(ra_valid), .out_tag(ra_sat), .root(ra)
  );

  cvc_sqrt #(.W(W)) u_sqrt_m (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .in_tag(1'b0), .x(plastic_viscosity),
    .out_valid(rb_valid), .out_tag(rb_tag), .root(rb)
  );

  cvc_square_clamp #(.W(W)) u_sq (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(ra_valid && rb_valid), .in_sat(ra_sat | rb_tag),
    .root_a(ra), .root_b(rb),
    .floor_val(viscosity_floor), .ceil_val(viscosity_ceiling),
    .out_valid(m_axis_tvalid), .nu(nu), .out_sat(m_axis_tuser)
  );

  assign m_axis_tdata = TW'(nu);

endmodule

/* hdl/cvc_checker.sv */
// Port-level checks of the Casson viscosity clamp, bound to the top level.
// Depends on cvc_pkg and casson_viscosity_clamp.
module cvc_checker
  import cvc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            pready,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind casson_viscosity_clamp cvc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cvc_checker (
  .clk(clk), .rst(rst), .pready(pready), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
